[design/url_percent_utf8_decoder_unit_macros.svh]
// Assertion macros shared by the decoder files.
`ifndef URL_PERCENT_UTF8_DECODER_UNIT_MACROS_SVH
`define URL_PERCENT_UTF8_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge, skipped while reset is high.
`define URLUTF_ASSERT(lbl, clock, reset, prop) \
  lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
    else $error("url decoder check failed");

// Check that a condition never holds, skipped while reset is high.
`define URLUTF_NEVER(lbl, clock, reset, cond) \
  lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
    else $error("url decoder forbidden condition");

`else

`define URLUTF_ASSERT(lbl, clock, reset, prop)
`define URLUTF_NEVER(lbl, clock, reset, cond)

`endif

`endif

[design/urlutf_pkg.sv]
package urlutf_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CP_W   = 31;
  localparam int unsigned REM_W  = 3;

  localparam logic [CHAR_W-1:0] CHAR_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

  // UTF-8 byte classes: (byte & mask) == code
  localparam logic [CHAR_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [CHAR_W-1:0] CONT_CODE  = 8'h80;
  localparam logic [CHAR_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [CHAR_W-1:0] LEAD2_CODE = 8'hC0;
  localparam logic [CHAR_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [CHAR_W-1:0] LEAD3_CODE = 8'hE0;
  localparam logic [CHAR_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [CHAR_W-1:0] LEAD4_CODE = 8'hF0;
  localparam logic [CHAR_W-1:0] LEAD5_MASK = 8'hFC;
  localparam logic [CHAR_W-1:0] LEAD5_CODE = 8'hF8;

  localparam logic [CHAR_W-1:0] PAY2_MASK = 8'h1F;
  localparam logic [CHAR_W-1:0] PAY3_MASK = 8'h0F;
  localparam logic [CHAR_W-1:0] PAY4_MASK = 8'h07;
  localparam logic [CHAR_W-1:0] PAY5_MASK = 8'h03;
  localparam logic [CHAR_W-1:0] PAY6_MASK = 8'h01;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              last_char;
  } in_word_t;

  typedef struct packed {
    logic            valid_res;
    logic [CP_W-1:0] code_point;
    logic            string_end;
    logic            aborted;
  } res_word_t;

  // Hex digit value; anything that is not a hex digit reads as zero.
  function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] ch);
    logic [3:0] v;
    v = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      v = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      v = 4'(ch[2:0] + 3'd1) + 4'd8;
    end
    return v;
  endfunction

endpackage

[design/urlutf_in_stage.sv]
module urlutf_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] in_char
  input  logic                s_tlast,   // last_char
  input  logic                advance,
  output logic                word_valid,
  output urlutf_pkg::in_word_t word
);
  import urlutf_pkg::*;

  // Take a new word when empty or when the held word moves on this cycle.
  assign s_tready = !word_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (s_tready) begin
      word_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      word.in_char   <= s_tdata;
      word.last_char <= s_tlast;
    end
  end

endmodule

[design/urlutf_core.sv]
`include "url_percent_utf8_decoder_unit_macros.svh"

module urlutf_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  urlutf_pkg::in_word_t word,
  output urlutf_pkg::res_word_t res
);
  import urlutf_pkg::*;

  esc_phase_t        phase;
  esc_phase_t        phase_next;
  logic [3:0]        nibble;
  logic [3:0]        nibble_next;
  logic [CP_W-1:0]   acc;
  logic [CP_W-1:0]   acc_next;
  logic [REM_W-1:0]  remaining;
  logic [REM_W-1:0]  remaining_next;
  logic              have_byte;
  logic [CHAR_W-1:0] dbyte;

  // Percent escape: produce one decoded byte or consume the character.
  always_comb begin
    phase_next  = phase;
    nibble_next = nibble;
    have_byte   = 1'b0;
    dbyte       = '0;
    unique case (phase)
      ESC_HIGH: begin
        nibble_next = hex_value(word.in_char);
        phase_next  = ESC_LOW;
      end
      ESC_LOW: begin
        dbyte      = {nibble, hex_value(word.in_char)};
        phase_next = ESC_IDLE;
        have_byte  = 1'b1;
      end
      default: begin
        if (word.in_char == CHAR_PERCENT) begin
          phase_next = ESC_HIGH;
        end else begin
          dbyte      = (word.in_char == CHAR_PLUS) ? CHAR_SPACE : word.in_char;
          phase_next = ESC_IDLE;
          have_byte  = 1'b1;
        end
      end
    endcase
  end

  // UTF-8 assembly and result.
  always_comb begin
    acc_next       = acc;
    remaining_next = remaining;
    res.valid_res  = 1'b0;
    res.code_point = '0;
    if (have_byte) begin
      priority if ((dbyte & CONT_MASK) == CONT_CODE) begin
        if (remaining != '0) begin
          acc_next       = {acc[CP_W-7:0], dbyte[5:0]};
          remaining_next = remaining - 3'd1;
          if (remaining == 3'd1) begin
            res.valid_res  = 1'b1;
            res.code_point = acc_next;
          end
        end
      end else if (!dbyte[7]) begin
        res.valid_res  = 1'b1;
        res.code_point = CP_W'(dbyte);
      end else if ((dbyte & LEAD2_MASK) == LEAD2_CODE) begin
        acc_next       = CP_W'(dbyte & PAY2_MASK);
        remaining_next = 3'd1;
      end else if ((dbyte & LEAD3_MASK) == LEAD3_CODE) begin
        acc_next       = CP_W'(dbyte & PAY3_MASK);
        remaining_next = 3'd2;
      end else if ((dbyte & LEAD4_MASK) == LEAD4_CODE) begin
        acc_next       = CP_W'(dbyte & PAY4_MASK);
        remaining_next = 3'd3;
      end else if ((dbyte & LEAD5_MASK) == LEAD5_CODE) begin
        acc_next       = CP_W'(dbyte & PAY5_MASK);
        remaining_next = 3'd4;
      end else begin
        acc_next       = CP_W'(dbyte & PAY6_MASK);
        remaining_next = 3'd5;
      end
    end
    res.string_end = word.last_char;
    res.aborted    = word.last_char && (phase_next != ESC_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= ESC_IDLE;
      nibble    <= '0;
      acc       <= '0;
      remaining <= '0;
    end else if (take) begin
      if (word.last_char) begin
        phase     <= ESC_IDLE;
        nibble    <= '0;
        acc       <= '0;
        remaining <= '0;
      end else begin
        phase     <= phase_next;
        nibble    <= nibble_next;
        acc       <= acc_next;
        remaining <= remaining_next;
      end
    end
  end

  `URLUTF_NEVER(a_rem_range, clk, rst, remaining > 3'd5)
  `URLUTF_ASSERT(a_end_clears, clk, rst, take && word.last_char |=> phase == ESC_IDLE && remaining == '0 && acc == '0)
  `URLUTF_ASSERT(a_multi_on_last, clk, rst, take && res.valid_res && res.code_point[CP_W-1:7] != '0 |-> remaining == 3'd1)
  `URLUTF_NEVER(a_open_esc_no_byte, clk, rst, have_byte && phase == ESC_HIGH)

endmodule

[design/urlutf_out_stage.sv]
module urlutf_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  urlutf_pkg::res_word_t res,
  output logic                  room,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [30:0] code_point, [31] zero
  output logic [1:0]            m_tuser,   // [0] valid_res, [1] aborted
  output logic                  m_tlast    // string_end
);
  import urlutf_pkg::*;

  res_word_t held;

  // Accept a new result when empty or when the held one leaves this cycle.
  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (room) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {1'b0, held.code_point};
  assign m_tuser = {held.aborted, held.valid_res};
  assign m_tlast = held.string_end;

endmodule

[design/url_percent_utf8_decoder_unit.sv]
// Channel   Dir  Handshake          tdata              tuser                   tlast
// s_        in   s_tvalid/s_tready  [7:0] in_char      -                       last_char
// m_        out  m_tvalid/m_tready  [30:0] code_point  [0] valid_res [1] abort string_end
//
// One result word per input word, one word per cycle sustained while m_tready is high.
// Path: input register, then decode into the result register.
// The escape and UTF-8 state advance when a word moves into the result register.
// rst (synchronous, active high) empties both registers and clears decoder state.
// A stall on m_tready holds the result; s_tready drops while the input word is held.
`include "url_percent_utf8_decoder_unit_macros.svh"

module url_percent_utf8_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_char
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [30:0] code_point, [31] zero
  output logic [1:0]  m_tuser,   // [0] valid_res, [1] aborted
  output logic        m_tlast    // string_end
);
  import urlutf_pkg::*;

  in_word_t  in_word;
  logic      in_valid;
  res_word_t res;
  logic      room;
  logic      advance;

  // Move the held input word into the result register when there is room.
  assign advance = in_valid && room;

  urlutf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .advance    (advance),
    .word_valid (in_valid),
    .word       (in_word)
  );

  // Decode one character per advance; state updates on the same edge.
  urlutf_core u_core (
    .clk  (clk),
    .rst  (rst),
    .take (advance),
    .word (in_word),
    .res  (res)
  );

  urlutf_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res      (res),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // An abort only ever comes with the end of a string.
  `URLUTF_ASSERT(a_abort_at_end, clk, rst, m_tvalid && m_tuser[1] |-> m_tlast)
  // No code point without the valid flag.
  `URLUTF_ASSERT(a_cp_needs_valid, clk, rst, m_tvalid && !m_tuser[0] |-> m_tdata == '0)
  // A word moved on forward shows up as a result on the next edge.
  `URLUTF_ASSERT(a_advance_loads, clk, rst, advance |=> m_tvalid)

endmodule
